// ===== rtl/brkd_pkg.sv =====
// Shared types and constants for the braille key report decoder.
package brkd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COLS_W = 7;
    localparam int unsigned CMD_W  = 5;

    localparam logic [BYTE_W-1:0] HDR0 = 8'h10;
    localparam logic [BYTE_W-1:0] HDR1 = 8'h02;
    localparam logic [BYTE_W-1:0] HDR2 = 8'h88;

    localparam logic [COLS_W-1:0] COLS_RESET = 7'd40;
    localparam logic [COLS_W-1:0] COLS_HOME  = 7'd20;

    // front keys, byte B
    localparam logic [BYTE_W-1:0] FK_DOWN  = 8'h01;
    localparam logic [BYTE_W-1:0] FK_RIGHT = 8'h02;
    localparam logic [BYTE_W-1:0] FK_CLICK = 8'h04;
    localparam logic [BYTE_W-1:0] FK_LEFT  = 8'h08;
    localparam logic [BYTE_W-1:0] FK_UP    = 8'h10;

    // function keys, bytes C and D
    localparam logic [BYTE_W-1:0] FN_F2    = 8'h02;
    localparam logic [BYTE_W-1:0] FN_F5    = 8'h10;
    localparam logic [BYTE_W-1:0] FN_SHIFT = 8'h40;
    localparam logic [BYTE_W-1:0] FN_F8    = 8'h80;

    // status sensors, byte A
    localparam logic [BYTE_W-1:0] ST_HELP     = 8'hD5;
    localparam logic [BYTE_W-1:0] ST_PREFMENU = 8'hD6;
    localparam logic [BYTE_W-1:0] ST_DISPMODE = 8'hD0;
    localparam logic [BYTE_W-1:0] ST_INFO     = 8'hD1;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE        = 5'd0,
        CMD_SHOW_HELP   = 5'd1,
        CMD_PREF_MENU   = 5'd2,
        CMD_DISPMODE    = 5'd3,
        CMD_STATUS_INFO = 5'd4,
        CMD_LINEDOWN    = 5'd5,
        CMD_WINRIGHT    = 5'd6,
        CMD_GO_HOME     = 5'd7,
        CMD_WINLEFT     = 5'd8,
        CMD_LINEUP      = 5'd9,
        CMD_TOP         = 5'd10,
        CMD_BOTTOM      = 5'd11,
        CMD_HALFLEFT    = 5'd12,
        CMD_HALFRIGHT   = 5'd13,
        CMD_CSRTRACK    = 5'd14,
        CMD_CURSOR_SHOW = 5'd15,
        CMD_SIX_DOT     = 5'd16
    } cmd_t;

    // report bytes held before the last one arrives
    typedef struct packed {
        logic [BYTE_W-1:0] sensor;
        logic [BYTE_W-1:0] front;
        logic [BYTE_W-1:0] func;
    } report_t;

endpackage

// ===== rtl/braille_key_report_decoder_core.sv =====
// Top level: header hunt, report capture and registered command output.
//
//  channel | direction | tdata bits (low first)   | tuser / tlast
//  s_      | in        | rx_byte [7:0]            | none
//  m_      | out       | command [4:0], 0 [7:5]   | none
//  cfg_    | in        | display_columns [6:0]    | write enable only
//
// One byte is taken per cycle; a command word appears in the cycle after the
// fourth report byte, from a single output register.
// Input stalls only while that register holds a word that is not taken.
// aresetn is synchronous, active low; display_columns resets to 40.
module braille_key_report_decoder_core
    import brkd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [COLS_W-1:0] cfg_wdata,  // display_columns [6:0]
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // rx_byte [7:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata     // command [4:0], zero [7:5]
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_HDR2   = 3'd2,
        PH_BYTE_A = 3'd3,
        PH_BYTE_B = 3'd4,
        PH_BYTE_C = 3'd5,
        PH_BYTE_D = 3'd6
    } phase_t;

    phase_t            phase_reg, phase_next;
    report_t           report_reg, report_next;
    logic [COLS_W-1:0] cols_reg;
    logic              m_valid_reg, m_valid_next;
    cmd_t              cmd_reg, cmd_next;
    cmd_t              dec_cmd;
    logic              s_accept;
    logic              restart;

    brkd_decode u_decode (
        .report          (report_reg),
        .last_byte       (s_tdata),
        .display_columns (cols_reg),
        .command         (dec_cmd)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign restart  = (s_tdata == HDR0);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, cmd_reg};

    always_comb begin
        phase_next   = phase_reg;
        report_next  = report_reg;
        cmd_next     = cmd_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (s_accept) begin
            unique case (phase_reg)
                PH_HDR1:   phase_next = (s_tdata == HDR1) ? PH_HDR2
                                      : (restart ? PH_HDR1 : PH_HUNT);
                PH_HDR2:   phase_next = (s_tdata == HDR2) ? PH_BYTE_A
                                      : (restart ? PH_HDR1 : PH_HUNT);
                PH_BYTE_A: begin
                    report_next.sensor = s_tdata;
                    phase_next         = PH_BYTE_B;
                end
                PH_BYTE_B: begin
                    report_next.front = s_tdata;
                    phase_next        = PH_BYTE_C;
                end
                PH_BYTE_C: begin
                    report_next.func = s_tdata;
                    phase_next       = PH_BYTE_D;
                end
                PH_BYTE_D: begin
                    cmd_next     = dec_cmd;
                    m_valid_next = 1'b1;
                    phase_next   = PH_HUNT;
                end
                default:   phase_next = restart ? PH_HDR1 : PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            m_valid_reg <= 1'b0;
            cols_reg    <= COLS_RESET;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen) begin
                cols_reg <= cfg_wdata;
            end
        end
        report_reg <= report_next;
        cmd_reg    <= cmd_next;
    end

    a_last_byte_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == PH_BYTE_D |=> m_valid_reg && phase_reg == PH_HUNT)
        else $error("report end did not load a command word");

    a_no_spurious_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg && !(s_accept && phase_reg == PH_BYTE_D) |=> !m_valid_reg)
        else $error("command word appeared without a report");

    a_header_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == PH_HUNT && s_tdata == HDR0 |=> phase_reg == PH_HDR1)
        else $error("header hunt missed first byte");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while output word is stalled");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> cmd_reg <= CMD_SIX_DOT)
        else $error("command code out of range");

endmodule

// ===== rtl/brkd_decode.sv =====
// Priority decode of one key report into a command code.
module brkd_decode
    import brkd_pkg::*;
(
    input  report_t           report,
    input  logic [BYTE_W-1:0] last_byte,
    input  logic [COLS_W-1:0] display_columns,
    output cmd_t              command
);

    cmd_t sensor_cmd;
    cmd_t single_cmd;

    always_comb begin
        sensor_cmd = CMD_NONE;
        unique case (report.sensor)
            ST_HELP:     sensor_cmd = CMD_SHOW_HELP;
            ST_PREFMENU: sensor_cmd = CMD_PREF_MENU;
            ST_DISPMODE: sensor_cmd = CMD_DISPMODE;
            ST_INFO:     sensor_cmd = CMD_STATUS_INFO;
            default:     sensor_cmd = CMD_NONE;
        endcase
    end

    // single front key overrides sensor; click alone only on 20-column units
    always_comb begin
        single_cmd = sensor_cmd;
        unique case (report.front)
            FK_DOWN:  single_cmd = CMD_LINEDOWN;
            FK_RIGHT: single_cmd = CMD_WINRIGHT;
            FK_CLICK: single_cmd = (display_columns == COLS_HOME) ? CMD_GO_HOME : sensor_cmd;
            FK_LEFT:  single_cmd = CMD_WINLEFT;
            FK_UP:    single_cmd = CMD_LINEUP;
            default:  single_cmd = sensor_cmd;
        endcase
    end

    always_comb begin
        if (report.front == (FK_UP | FK_CLICK)) begin
            command = CMD_TOP;
        end else if (report.front == (FK_DOWN | FK_CLICK)) begin
            command = CMD_BOTTOM;
        end else if (report.front == (FK_LEFT | FK_CLICK)) begin
            command = CMD_HALFLEFT;
        end else if (report.front == (FK_RIGHT | FK_CLICK)) begin
            command = CMD_HALFRIGHT;
        end else if (report.func == FN_SHIFT && last_byte == FN_F8) begin
            command = CMD_CSRTRACK;
        end else if (last_byte == FN_F2) begin
            command = CMD_GO_HOME;
        end else if (last_byte == FN_F5) begin
            command = CMD_CURSOR_SHOW;
        end else if (last_byte == FN_F8) begin
            command = CMD_SIX_DOT;
        end else begin
            command = single_cmd;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the braille key report decoder core: random byte streams, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
    import brkd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int N_BYTES     = 1150;
    localparam int N_PHASES    = 7;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SEEN10,
        PH_SEEN02,
        PH_BYTE_A,
        PH_BYTE_B,
        PH_BYTE_C,
        PH_BYTE_D
    } parse_phase_t;

    class key_cmd_scoreboard;
        parse_phase_t      phase;
        logic [7:0]        sensor;
        logic [7:0]        front;
        logic [7:0]        func;
        logic [COLS_W-1:0] columns;
        cmd_t              pending_cmds[$];
        int                n_bad;

        function new();
            phase   = PH_HUNT;
            sensor  = '0;
            front   = '0;
            func    = '0;
            columns = COLS_RESET;
            n_bad   = 0;
        endfunction

        function cmd_t decode_keys(logic [7:0] fkeys_d);
            cmd_t cmd;
            cmd = CMD_NONE;
            if (front == (FK_UP | FK_CLICK)) return CMD_TOP;
            if (front == (FK_DOWN | FK_CLICK)) return CMD_BOTTOM;
            if (front == (FK_LEFT | FK_CLICK)) return CMD_HALFLEFT;
            if (front == (FK_RIGHT | FK_CLICK)) return CMD_HALFRIGHT;
            if (func == FN_SHIFT && fkeys_d == FN_F8) return CMD_CSRTRACK;
            if (fkeys_d == FN_F2) return CMD_GO_HOME;
            if (fkeys_d == FN_F5) return CMD_CURSOR_SHOW;
            if (fkeys_d == FN_F8) return CMD_SIX_DOT;
            case (sensor)
                ST_HELP:     cmd = CMD_SHOW_HELP;
                ST_PREFMENU: cmd = CMD_PREF_MENU;
                ST_DISPMODE: cmd = CMD_DISPMODE;
                ST_INFO:     cmd = CMD_STATUS_INFO;
                default:     ;
            endcase
            case (front)
                FK_DOWN:  cmd = CMD_LINEDOWN;
                FK_RIGHT: cmd = CMD_WINRIGHT;
                FK_CLICK: begin
                    if (columns == COLS_HOME) cmd = CMD_GO_HOME;
                end
                FK_LEFT:  cmd = CMD_WINLEFT;
                FK_UP:    cmd = CMD_LINEUP;
                default:  ;
            endcase
            return cmd;
        endfunction

        function void note_byte(logic [7:0] b);
            parse_phase_t restart;
            restart = (b == HDR0) ? PH_SEEN10 : PH_HUNT;
            case (phase)
                PH_SEEN10: phase = (b == HDR1) ? PH_SEEN02 : restart;
                PH_SEEN02: phase = (b == HDR2) ? PH_BYTE_A : restart;
                PH_BYTE_A: begin
                    sensor = b;
                    phase  = PH_BYTE_B;
                end
                PH_BYTE_B: begin
                    front = b;
                    phase = PH_BYTE_C;
                end
                PH_BYTE_C: begin
                    func  = b;
                    phase = PH_BYTE_D;
                end
                PH_BYTE_D: begin
                    pending_cmds.push_back(decode_keys(b));
                    phase = PH_HUNT;
                end
                default:   phase = restart;
            endcase
        endfunction

        function void flag(string msg);
            if (n_bad < 10) $display("ERROR at %0t: %s", $time, msg);
            n_bad++;
        endfunction

        function void check_word(logic [7:0] w);
            cmd_t want;
            if (pending_cmds.size() == 0) begin
                flag($sformatf("unexpected word 0x%02h", w));
            end else begin
                want = pending_cmds.pop_front();
                if (w !== {3'b000, want})
                    flag($sformatf("command expected %0d (%s) got 0x%02h",
                                   want, want.name(), w));
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic [COLS_W-1:0] cfg_wdata = COLS_RESET;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;

    key_cmd_scoreboard sb;
    int                burst_left = 0;
    bit                no_gaps    = 1'b0;
    bit                hold_req   = 1'b0;
    int                n_sent     = 0;
    int                idle_cnt   = 0;

    braille_key_report_decoder_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        n_sent++;
    endtask

    task automatic send_report(input logic [7:0] a, b, c, d);
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR2);
        send_byte(a);
        send_byte(b);
        send_byte(c);
        send_byte(d);
    endtask

    task automatic write_columns(input logic [COLS_W-1:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wen    <= 1'b1;
        cfg_wdata  <= v;
        sb.columns = v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // word checks and byte notes on accepted handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // receiver: stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int len;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(5, 60);
                for (int i = 0; i < len; i++) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= (i % 4) != 0;
                        default: m_tready <= (i % 7) < 2;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [COLS_W-1:0] col_set[N_PHASES];
        logic [7:0]        a, b, c, d;
        int                n;
        sb = new();
        col_set = '{COLS_HOME, 7'd80, 7'd21, 7'd79, 7'd63, 7'd40, COLS_RESET};
        col_set[5] = 7'($urandom_range(20, 80));
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        // header broken by 0x10 in its third place restarts the hunt
        send_byte(HDR0);
        send_byte(HDR1);
        send_report(ST_HELP, FK_CLICK, 8'h00, 8'h00);
        // repeated 0x10, then 0x10 as report bytes
        send_byte(HDR0);
        send_report(HDR0, HDR0, HDR0, HDR0);
        send_report(8'hFF, FK_UP | FK_CLICK, FN_SHIFT, FN_F8);

        for (int p = 0; p < N_PHASES; p++) begin
            write_columns(col_set[p]);
            no_gaps = (p == 3);
            if (p == 2) hold_req = 1'b1;
            while (n_sent < (p + 1) * N_BYTES / N_PHASES) begin
                case ($urandom_range(0, 9))
                    8: begin
                        n = $urandom_range(1, 6);
                        repeat (n) send_byte(($urandom_range(0, 3) == 0) ? HDR0
                                             : 8'($urandom_range(0, 255)));
                    end
                    9: begin
                        send_byte(HDR0);
                        if ($urandom_range(0, 1)) send_byte(HDR1);
                        send_byte($urandom_range(0, 1) ? HDR0 : 8'($urandom_range(0, 255)));
                    end
                    default: begin
                        case ($urandom_range(0, 5))
                            0:       a = ST_HELP;
                            1:       a = ST_PREFMENU;
                            2:       a = ST_DISPMODE;
                            3:       a = ST_INFO;
                            default: a = 8'($urandom_range(0, 255));
                        endcase
                        case ($urandom_range(0, 11))
                            0:       b = FK_DOWN;
                            1:       b = FK_RIGHT;
                            2:       b = FK_CLICK;
                            3:       b = FK_LEFT;
                            4:       b = FK_UP;
                            5:       b = FK_UP | FK_CLICK;
                            6:       b = FK_DOWN | FK_CLICK;
                            7:       b = FK_LEFT | FK_CLICK;
                            8:       b = FK_RIGHT | FK_CLICK;
                            9:       b = 8'h00;
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                        c = ($urandom_range(0, 2) == 0) ? FN_SHIFT : 8'($urandom_range(0, 255));
                        case ($urandom_range(0, 6))
                            0:       d = FN_F2;
                            1:       d = FN_F5;
                            2:       d = FN_F8;
                            3:       d = 8'h00;
                            default: d = 8'($urandom_range(0, 255));
                        endcase
                        send_report(a, b, c, d);
                    end
                endcase
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.n_bad == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/brkd_pkg.sv
rtl/brkd_decode.sv
rtl/braille_key_report_decoder_core.sv
tb/tb_top.sv
